// ----- hdl/xspl_pkg.sv -----
// ----------------------------------------------------------------------------
// xspl_pkg
// shared types and constants of the padding length generator
// ----------------------------------------------------------------------------
package xspl_pkg;

  localparam int unsigned STREAM_MAX_LEN = 1440;
  localparam int unsigned TIER_HI_LEN    = 1300;
  localparam int unsigned TIER_MID_LEN   = 900;
  localparam int unsigned TIER_LO_LEN    = 400;
  localparam logic [9:0]  TIER_HI        = 10'd31;
  localparam logic [9:0]  TIER_MID       = 10'd127;
  localparam logic [9:0]  TIER_LO        = 10'd521;
  localparam logic [9:0]  TIER_MIN       = 10'd1021;
  localparam logic [9:0]  DGRAM_MOD      = 10'd127;
  localparam logic [33:0] START_MOD      = 34'd8589934609;

  localparam int unsigned SHL_A = 23;
  localparam int unsigned SHR_B = 17;
  localparam int unsigned SHR_C = 26;

  localparam int unsigned NUM_WARM  = 4;
  localparam int unsigned GEN_CELLS = NUM_WARM + 2;
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned AB_CELLS  = 64 / DIV_BITS;
  // 34-bit remainder sits in the top 40 dividend bits
  localparam int unsigned C_CELLS   = 40 / DIV_BITS;

  typedef struct packed {
    logic       valid;
    logic       dgram;
    logic       skip;
    logic       len_nz;
    logic [9:0] tier;
    logic [9:0] pad;
  } side_t;

  typedef struct packed {
    logic [63:0] s0;
    logic [63:0] s1;
    logic [63:0] draw_a;
    logic [63:0] draw_b;
  } gen_t;

  typedef struct packed {
    logic [63:0] v;
    logic [33:0] r;
    logic [33:0] d;
  } mod_t;

endpackage

// ----- hdl/xspl_if.sv -----
// ----------------------------------------------------------------------------
// xspl_in_if / xspl_out_if
// valid/ready channels for request and result items
// ----------------------------------------------------------------------------
interface xspl_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] hash_low;
  logic [63:0] hash_high;
  logic [15:0] pkt_len;
  modport source (output valid, req_type, hash_low, hash_high, pkt_len, input ready);
  modport sink   (input valid, req_type, hash_low, hash_high, pkt_len, output ready);
endinterface

interface xspl_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] pad_len;
  logic [9:0] pay_offset;
  modport source (output valid, pad_len, pay_offset, input ready);
  modport sink   (input valid, pad_len, pay_offset, output ready);
endinterface

// ----- hdl/xspl_gen_cell.sv -----
// ----------------------------------------------------------------------------
// xspl_gen_cell
// one xorshift128+ step per cell, captures the draws it is assigned
// ----------------------------------------------------------------------------
module xspl_gen_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic [2:0]      step,
  input  xspl_pkg::side_t side_in,
  input  xspl_pkg::gen_t  gen_in,
  output xspl_pkg::side_t side_r,
  output xspl_pkg::gen_t  gen_r
);

  logic [63:0] x1, x2, sum;
  xspl_pkg::gen_t gen_nxt;

  always_comb begin
    x1  = gen_in.s0 ^ (gen_in.s0 << xspl_pkg::SHL_A);
    x2  = x1 ^ gen_in.s1 ^ (x1 >> xspl_pkg::SHR_B) ^ (gen_in.s1 >> xspl_pkg::SHR_C);
    sum = x2 + gen_in.s1;
    gen_nxt    = gen_in;
    gen_nxt.s0 = gen_in.s1;
    gen_nxt.s1 = x2;
    if ((side_in.dgram && step == 3'd0) ||
        (!side_in.dgram && step == 3'(xspl_pkg::NUM_WARM))) begin
      gen_nxt.draw_a = sum;
    end
    if (step == 3'(xspl_pkg::NUM_WARM + 1)) begin
      gen_nxt.draw_b = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.valid <= 1'b0;
    end else if (en) begin
      side_r <= side_in;
    end
    if (en) begin
      gen_r <= gen_nxt;
    end
  end

endmodule

// ----- hdl/xspl_mod_cell.sv -----
// ----------------------------------------------------------------------------
// xspl_mod_cell
// remainder cell, folds four dividend bits into the partial remainder
// ----------------------------------------------------------------------------
module xspl_mod_cell (
  input  logic           clk,
  input  logic           en,
  input  xspl_pkg::mod_t mod_in,
  output xspl_pkg::mod_t mod_r
);

  xspl_pkg::mod_t mod_nxt;
  logic [34:0]    t;

  always_comb begin
    mod_nxt = mod_in;
    t       = '0;
    for (int i = 0; i < xspl_pkg::DIV_BITS; i++) begin
      t = {mod_nxt.r, mod_nxt.v[63]};
      if (t >= {1'b0, mod_nxt.d}) begin
        t = t - {1'b0, mod_nxt.d};
      end
      mod_nxt.r = t[33:0];
      mod_nxt.v = {mod_nxt.v[62:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mod_r <= mod_nxt;
    end
  end

endmodule

// ----- hdl/xorshift_padding_length.sv -----
// ----------------------------------------------------------------------------
// xorshift_padding_length
// padding length and payload offset from a xorshift128+ chain
// an item passes 6 generator cells, 16 + 10 remainder cells and the output register
// throughput: one item per cycle, the whole chain advances unless the
//   output register holds an item that is not taken
// reset: synchronous active-low rst_n clears all valid bits
// ----------------------------------------------------------------------------
module xorshift_padding_length (
  input  logic clk,
  input  logic rst_n,
  xspl_in_if.sink    in_ch,
  xspl_out_if.source out_ch
);

  logic en;
  xspl_pkg::side_t side_in;
  xspl_pkg::gen_t  gen_in;
  xspl_pkg::side_t gs   [0:xspl_pkg::GEN_CELLS];
  xspl_pkg::gen_t  gg   [0:xspl_pkg::GEN_CELLS];
  xspl_pkg::side_t sab  [0:xspl_pkg::AB_CELLS];
  xspl_pkg::mod_t  ma   [0:xspl_pkg::AB_CELLS];
  xspl_pkg::mod_t  mb   [0:xspl_pkg::AB_CELLS];
  xspl_pkg::side_t sc   [0:xspl_pkg::C_CELLS];
  xspl_pkg::mod_t  mc   [0:xspl_pkg::C_CELLS];
  logic [9:0] pad_a;
  logic       out_valid_r;
  logic [9:0] pad_r, pad_nxt, start_r, start_nxt;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // front: tier select and seeding
  always_comb begin
    side_in.valid  = in_ch.valid;
    side_in.dgram  = in_ch.req_type;
    side_in.skip   = !in_ch.req_type && (in_ch.pkt_len > 16'(xspl_pkg::STREAM_MAX_LEN));
    side_in.len_nz = in_ch.pkt_len != 16'd0;
    side_in.pad    = '0;
    priority if (in_ch.req_type) begin
      side_in.tier = xspl_pkg::DGRAM_MOD;
    end else if (in_ch.pkt_len > 16'(xspl_pkg::TIER_HI_LEN)) begin
      side_in.tier = xspl_pkg::TIER_HI;
    end else if (in_ch.pkt_len > 16'(xspl_pkg::TIER_MID_LEN)) begin
      side_in.tier = xspl_pkg::TIER_MID;
    end else if (in_ch.pkt_len > 16'(xspl_pkg::TIER_LO_LEN)) begin
      side_in.tier = xspl_pkg::TIER_LO;
    end else begin
      side_in.tier = xspl_pkg::TIER_MIN;
    end
    gen_in.s0     = in_ch.req_type ? in_ch.hash_low : {in_ch.hash_low[63:16], in_ch.pkt_len};
    gen_in.s1     = in_ch.hash_high;
    gen_in.draw_a = '0;
    gen_in.draw_b = '0;
  end

  assign gs[0] = side_in;
  assign gg[0] = gen_in;

  for (genvar i = 0; i < xspl_pkg::GEN_CELLS; i++) begin : g_gen
    xspl_gen_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .step(3'(i)),
      .side_in(gs[i]), .gen_in(gg[i]), .side_r(gs[i+1]), .gen_r(gg[i+1])
    );
  end

  assign sab[0] = gs[xspl_pkg::GEN_CELLS];
  assign ma[0]  = '{v: gg[xspl_pkg::GEN_CELLS].draw_a, r: '0,
                    d: {24'd0, gs[xspl_pkg::GEN_CELLS].tier}};
  assign mb[0]  = '{v: gg[xspl_pkg::GEN_CELLS].draw_b, r: '0, d: xspl_pkg::START_MOD};

  for (genvar i = 0; i < xspl_pkg::AB_CELLS; i++) begin : g_ab
    xspl_mod_cell u_a (.clk(clk), .en(en), .mod_in(ma[i]), .mod_r(ma[i+1]));
    xspl_mod_cell u_b (.clk(clk), .en(en), .mod_in(mb[i]), .mod_r(mb[i+1]));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sab[i+1].valid <= 1'b0;
      end else if (en) begin
        sab[i+1] <= sab[i];
      end
    end
  end

  assign pad_a = sab[xspl_pkg::AB_CELLS].skip ? 10'd0 : ma[xspl_pkg::AB_CELLS].r[9:0];

  always_comb begin
    sc[0]     = sab[xspl_pkg::AB_CELLS];
    sc[0].pad = pad_a;
  end
  assign mc[0] = '{v: {6'd0, mb[xspl_pkg::AB_CELLS].r, 24'd0}, r: '0, d: {24'd0, pad_a}};

  for (genvar i = 0; i < xspl_pkg::C_CELLS; i++) begin : g_c
    xspl_mod_cell u_c (.clk(clk), .en(en), .mod_in(mc[i]), .mod_r(mc[i+1]));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sc[i+1].valid <= 1'b0;
      end else if (en) begin
        sc[i+1] <= sc[i];
      end
    end
  end

  always_comb begin
    pad_nxt   = sc[xspl_pkg::C_CELLS].pad;
    start_nxt = 10'd0;
    if (!sc[xspl_pkg::C_CELLS].dgram && sc[xspl_pkg::C_CELLS].len_nz && pad_nxt != 10'd0) begin
      start_nxt = mc[xspl_pkg::C_CELLS].r[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sc[xspl_pkg::C_CELLS].valid;
    end
    if (en) begin
      pad_r   <= pad_nxt;
      start_r <= start_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pad_len    = pad_r;
  assign out_ch.pay_offset = start_r;

  a_pad_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> pad_r <= 10'd1020)
    else $error("pad length out of range");
  a_start_below_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pad_r != 10'd0) |-> start_r < pad_r)
    else $error("start offset not below padding");
  a_zero_pad_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && pad_r == 10'd0) |-> start_r == 10'd0)
    else $error("start offset nonzero without padding");
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

endmodule
